[sv/pls_pkg.sv]
package pls_pkg;

    localparam int CMD_W      = 3;
    localparam int POS_W      = 7;
    localparam int DATA_W     = 32;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 7;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 48;

    // cells folded into one register of the select tree
    localparam int GROUP_SIZE = 8;

    localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INS_END   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INS_AT    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REM_FRONT = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REM_END   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_REM_AT    = 3'd5;
    localparam logic [CMD_W-1:0] CMD_READ      = 3'd6;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    typedef enum logic [1:0] {
        CH_HOLD,
        CH_INSERT,
        CH_REMOVE
    } t_chain_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_REDUCE,
        S_OUT
    } t_state;

endpackage

[sv/pls_cell.sv]
module pls_cell
    import pls_pkg::*;
#(
    parameter int VALUE_WIDTH = 32,
    parameter int PW          = 7,
    parameter int INDEX       = 0
) (
    input  logic                   i_clk,
    input  t_chain_op              i_op,
    input  logic [PW-1:0]          i_pos,
    input  logic [VALUE_WIDTH-1:0] i_new,
    input  logic [VALUE_WIDTH-1:0] i_left,
    input  logic [VALUE_WIDTH-1:0] i_right,
    output logic [VALUE_WIDTH-1:0] o_value,
    output logic [VALUE_WIDTH-1:0] o_sel
);

    localparam logic [PW-1:0] IDX = PW'(INDEX);

    logic [VALUE_WIDTH-1:0] r_value;

    // insert: fill the gap at pos, cells behind it take the left neighbor
    // remove: cells at and behind pos take the right neighbor
    always_ff @(posedge i_clk) begin
        unique case (i_op)
            CH_INSERT: begin
                if (IDX == i_pos) begin
                    r_value <= i_new;
                end else if (IDX > i_pos) begin
                    r_value <= i_left;
                end
            end
            CH_REMOVE: begin
                if (IDX >= i_pos) begin
                    r_value <= i_right;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_value = r_value;
    assign o_sel   = (IDX == i_pos) ? r_value : '0;

endmodule

[sv/pls_select_tree.sv]
module pls_select_tree
    import pls_pkg::*;
#(
    parameter int CAPACITY    = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_load,
    input  logic [CAPACITY*VALUE_WIDTH-1:0] i_cells,
    output logic [VALUE_WIDTH-1:0]          o_value
);

    localparam int NG = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

    logic [VALUE_WIDTH-1:0] r_grp [NG];

    for (genvar g = 0; g < NG; g++) begin : g_grp
        logic [VALUE_WIDTH-1:0] w_or;

        always_comb begin
            w_or = '0;
            for (int k = 0; k < GROUP_SIZE; k++) begin
                if (g * GROUP_SIZE + k < CAPACITY) begin
                    w_or = w_or | i_cells[(g*GROUP_SIZE+k)*VALUE_WIDTH +: VALUE_WIDTH];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_load) begin
                r_grp[g] <= w_or;
            end
        end
    end

    always_comb begin
        o_value = '0;
        for (int g = 0; g < NG; g++) begin
            o_value = o_value | r_grp[g];
        end
    end

endmodule

[sv/positional_list_store.sv]
// Channel   Direction  Payload (tdata, lowest bit first)
// --------  ---------  ----------------------------------------------------
// s_axis    request    cmd[2:0], position[9:3], item_value[41:10], zero fill
// m_axis    response   status[1:0], out_value[33:2], count[40:34], zero fill
//
// The accept edge shifts the cell chain and loads the select tree groups; the
// next edge folds the groups into the response register and raises m_axis_tvalid.
// One request is in flight at a time; s_axis_tready stays low until the
// response is taken, so a stall on m_axis holds the whole block.
// Reset (synchronous, active low) empties the list; cell contents are not
// cleared, since no cell at or beyond the count is ever returned.
module positional_list_store
    import pls_pkg::*;
#(
    parameter int CAPACITY    = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // cmd, position, item_value
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata    // status, out_value, count
);

    // count width holds CAPACITY itself; KW also covers the 7-bit position
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int KW = (CW > POS_W) ? CW : POS_W;

    t_state r_state, n_state;

    logic [CW-1:0]       r_count;
    logic [STATUS_W-1:0] r_status;
    logic                r_use_value;
    logic [DATA_W-1:0]   r_out_value;

    logic [CMD_W-1:0]  w_cmd;
    logic [POS_W-1:0]  w_position;
    logic [DATA_W-1:0] w_item;
    logic              w_accept;
    logic              w_reduce;

    logic [KW-1:0]       w_pos_k;
    logic [KW-1:0]       w_cnt_k;
    logic [KW-1:0]       w_next_cnt_k;
    logic [KW-1:0]       w_chain_pos;
    t_chain_op           w_op;
    t_chain_op           w_cell_op;
    logic [STATUS_W-1:0] w_status;
    logic                w_use_value;
    logic                w_full;
    logic                w_empty;

    logic [VALUE_WIDTH-1:0]          w_new;
    logic [VALUE_WIDTH-1:0]          w_val [CAPACITY];
    logic [CAPACITY*VALUE_WIDTH-1:0] w_sel_flat;
    logic [VALUE_WIDTH-1:0]          w_picked;
    logic [DATA_W-1:0]               w_picked32;

    assign w_cmd      = s_axis_tdata[CMD_W-1:0];
    assign w_position = s_axis_tdata[CMD_W +: POS_W];
    assign w_item     = s_axis_tdata[CMD_W+POS_W +: DATA_W];

    // fit the request value to the cell width, and a cell value to the port
    if (VALUE_WIDTH <= DATA_W) begin : g_narrow
        assign w_new      = w_item[VALUE_WIDTH-1:0];
        assign w_picked32 = DATA_W'(w_picked);
    end else begin : g_wide
        assign w_new      = VALUE_WIDTH'(w_item);
        assign w_picked32 = w_picked[DATA_W-1:0];
    end

    assign w_pos_k = KW'(w_position);
    assign w_cnt_k = KW'(r_count);
    assign w_full  = (w_cnt_k == KW'(CAPACITY));
    assign w_empty = (w_cnt_k == '0);

    // decode the request: chain operation, slot, status; full wins over range
    always_comb begin
        w_op        = CH_HOLD;
        w_chain_pos = '0;
        w_status    = ST_OK;
        w_use_value = 1'b0;
        unique case (w_cmd)
            CMD_INS_FRONT: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_op = CH_INSERT;
                end
            end
            CMD_INS_END: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_op        = CH_INSERT;
                    w_chain_pos = w_cnt_k;
                end
            end
            CMD_INS_AT: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else if (w_pos_k > w_cnt_k) begin
                    w_status = ST_RANGE;
                end else begin
                    w_op        = CH_INSERT;
                    w_chain_pos = w_pos_k;
                end
            end
            CMD_REM_FRONT: begin
                if (w_empty) begin
                    w_status = ST_RANGE;
                end else begin
                    w_op        = CH_REMOVE;
                    w_use_value = 1'b1;
                end
            end
            CMD_REM_END: begin
                if (w_empty) begin
                    w_status = ST_RANGE;
                end else begin
                    w_op        = CH_REMOVE;
                    w_chain_pos = w_cnt_k - KW'(1);
                    w_use_value = 1'b1;
                end
            end
            CMD_REM_AT: begin
                if (w_empty || (w_pos_k >= w_cnt_k)) begin
                    w_status = ST_RANGE;
                end else begin
                    w_op        = CH_REMOVE;
                    w_chain_pos = w_pos_k;
                    w_use_value = 1'b1;
                end
            end
            CMD_READ: begin
                if (w_pos_k >= w_cnt_k) begin
                    w_status = ST_RANGE;
                end else begin
                    w_chain_pos = w_pos_k;
                    w_use_value = 1'b1;
                end
            end
            default: begin
                w_status = ST_RANGE;
            end
        endcase
    end

    always_comb begin
        unique case (w_op)
            CH_INSERT: w_next_cnt_k = w_cnt_k + KW'(1);
            CH_REMOVE: w_next_cnt_k = w_cnt_k - KW'(1);
            default:   w_next_cnt_k = w_cnt_k;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (s_axis_tvalid) n_state = S_REDUCE;
            S_REDUCE: n_state = S_OUT;
            S_OUT:    if (m_axis_tready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        w_reduce      = 1'b0;
        unique case (r_state)
            S_IDLE:   s_axis_tready = 1'b1;
            S_REDUCE: w_reduce      = 1'b1;
            S_OUT:    m_axis_tvalid = 1'b1;
            default: begin
            end
        endcase
    end

    assign w_accept  = s_axis_tvalid && s_axis_tready;
    assign w_cell_op = w_accept ? w_op : CH_HOLD;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_count <= w_next_cnt_k[CW-1:0];
            end
        end
    end

    // payload: latch status at acceptance, the picked value after the fold
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status    <= w_status;
            r_use_value <= w_use_value;
        end
        if (w_reduce) begin
            r_out_value <= r_use_value ? w_picked32 : '0;
        end
    end

    // cell chain: each cell sees its two neighbors and the broadcast request
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [VALUE_WIDTH-1:0] w_left;
        logic [VALUE_WIDTH-1:0] w_right;

        if (i == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_val[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign w_right = w_val[i];
        end else begin : g_mid_r
            assign w_right = w_val[i+1];
        end

        pls_cell #(
            .VALUE_WIDTH (VALUE_WIDTH),
            .PW          (CW),
            .INDEX       (i)
        ) u_cell (
            .i_clk   (i_clk),
            .i_op    (w_cell_op),
            .i_pos   (w_chain_pos[CW-1:0]),
            .i_new   (w_new),
            .i_left  (w_left),
            .i_right (w_right),
            .o_value (w_val[i]),
            .o_sel   (w_sel_flat[i*VALUE_WIDTH +: VALUE_WIDTH])
        );
    end

    // the cell at the request slot is captured before the chain shifts
    pls_select_tree #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_select (
        .i_clk   (i_clk),
        .i_load  (w_accept),
        .i_cells (w_sel_flat),
        .o_value (w_picked)
    );

    logic [KW-1:0] w_count_out;
    assign w_count_out = KW'(r_count);

    assign m_axis_tdata = {
        (OUT_TDATA_W - STATUS_W - DATA_W - COUNT_W)'(0),
        w_count_out[COUNT_W-1:0],
        r_out_value,
        r_status
    };

endmodule

[sv/pls_checker.sv]
module pls_checker
    import pls_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic [STATUS_W-1:0] w_status;
    logic [DATA_W-1:0]   w_value;

    assign w_status = m_axis_tdata[STATUS_W-1:0];
    assign w_value  = m_axis_tdata[STATUS_W +: DATA_W];

    // a request is answered right after the fold that follows its acceptance
    a_resp_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |-> ##2 m_axis_tvalid)
        else $error("response missing two cycles after request");

    // no new request while a response waits
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("request taken while response pending");

    // one response per request
    a_single_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready) |=> !m_axis_tvalid)
        else $error("response repeated");

    // failed requests return no value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (w_status != ST_OK)) |-> (w_value == '0))
        else $error("value on failed request");

    // response held while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("response dropped or changed under stall");

endmodule

bind positional_list_store pls_checker u_pls_checker (.*);

[bench/tb_positional_list_store.sv]
`timescale 1ns / 1ps

// Self-checking bench for the positional list store. Requests are queued up
// front by the stimulus block, presented on s_axis by a falling-edge driver
// with random gaps, and each accepted request is run through a local list
// predictor. Responses on m_axis are taken with random backpressure and
// compared field by field against the oldest predicted response.
module tb_positional_list_store;
    import pls_pkg::*;

    localparam int LIST_CAPACITY = 64;
    localparam int CLK_PERIOD    = 10;
    localparam int TARGET_REQS   = 1450;
    localparam int MAX_REPORTS   = 100;

    // cmd encoding 7 is not a valid command; the block must flag it
    localparam logic [CMD_W-1:0] CMD_UNDEFINED = 3'd7;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [POS_W-1:0]  position;
        logic [DATA_W-1:0] item_value;
        bit                drain_first;  // hold until every response is back
    } t_list_request;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   out_value;
        logic [COUNT_W-1:0]  count;
    } t_list_response;

    typedef enum int {
        PH_GROW,
        PH_SHRINK,
        PH_MIX
    } t_phase_kind;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // cmd, position, item_value
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;        // status, out_value, count

    t_list_request  pending_requests[$];
    t_list_response expected_responses[$];
    logic [DATA_W-1:0] list_cells[$];   // predicted list, front at index 0

    int  mismatch_count = 0;
    int  request_total = 0;
    int  planned_count = 0;   // list length as seen by the stimulus generator
    int  send_gap = 0;
    int  recv_stall = 0;
    int  calm_cycles = 0;
    bit  req_taken = 1'b0;

    positional_list_store #(
        .CAPACITY    (LIST_CAPACITY),
        .VALUE_WIDTH (DATA_W)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Gap length for either side: mostly none or short, a few long. During a
    // calm stretch both sides run flat out.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm_cycles > 0) return 0;
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Apply one command to the predicted list and return the response it
    // should produce.
    function automatic t_list_response apply_list_command(
        logic [CMD_W-1:0] cmd, logic [POS_W-1:0] position, logic [DATA_W-1:0] value
    );
        t_list_response resp;
        int pos;
        int len;
        resp.status    = ST_OK;
        resp.out_value = '0;
        pos = int'(position);
        len = list_cells.size();
        case (cmd)
            CMD_INS_FRONT, CMD_INS_END, CMD_INS_AT: begin
                // full check wins over the position check
                if (len >= LIST_CAPACITY) begin
                    resp.status = ST_FULL;
                end else if (cmd == CMD_INS_FRONT) begin
                    list_cells.push_front(value);
                end else if (cmd == CMD_INS_END) begin
                    list_cells.push_back(value);
                end else if (pos > len) begin
                    resp.status = ST_RANGE;
                end else begin
                    list_cells.insert(pos, value);
                end
            end
            CMD_REM_FRONT, CMD_REM_END, CMD_REM_AT: begin
                if (len == 0) begin
                    resp.status = ST_RANGE;
                end else if (cmd == CMD_REM_FRONT) begin
                    resp.out_value = list_cells.pop_front();
                end else if (cmd == CMD_REM_END) begin
                    resp.out_value = list_cells.pop_back();
                end else if (pos >= len) begin
                    resp.status = ST_RANGE;
                end else begin
                    resp.out_value = list_cells[pos];
                    list_cells.delete(pos);
                end
            end
            CMD_READ: begin
                if (pos >= len) begin
                    resp.status = ST_RANGE;
                end else begin
                    resp.out_value = list_cells[pos];
                end
            end
            default: begin
                resp.status = ST_RANGE;
            end
        endcase
        resp.count = COUNT_W'(list_cells.size());
        return resp;
    endfunction

    // Queue one request and track the list length it leaves behind, so that
    // later positions can be aimed mostly inside the list.
    function automatic void queue_request(
        logic [CMD_W-1:0] cmd, int position, logic [DATA_W-1:0] value, bit drain_first
    );
        t_list_request req;
        req.cmd         = cmd;
        req.position    = POS_W'(position);
        req.item_value  = value;
        req.drain_first = drain_first;
        pending_requests.push_back(req);
        request_total++;
        case (cmd)
            CMD_INS_FRONT, CMD_INS_END, CMD_INS_AT: begin
                if (planned_count < LIST_CAPACITY
                        && !(cmd == CMD_INS_AT && position > planned_count))
                    planned_count++;
            end
            CMD_REM_FRONT, CMD_REM_END, CMD_REM_AT: begin
                if (planned_count > 0 && !(cmd == CMD_REM_AT && position >= planned_count))
                    planned_count--;
            end
            default: ;
        endcase
    endfunction

    // Position mostly within [0, limit], sometimes anywhere in the field.
    function automatic int pick_position(int limit);
        if ($urandom_range(0, 99) < 85) return $urandom_range(0, limit);
        return $urandom_range(0, 127);
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return '0;
        if (r < 10) return '1;
        return $urandom;
    endfunction

    task automatic report_mismatch(string what, longint unsigned want, longint unsigned got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected 0x%0h got 0x%0h", $realtime, what, want, got);
    endtask

    // Request driver: present requests at the falling edge, hold each one
    // until it is taken, then idle for a random gap.
    always @(negedge i_clk) begin
        t_list_request req;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && !req_taken) begin
            // hold the current request
        end else if (send_gap > 0) begin
            s_axis_tvalid <= 1'b0;
            send_gap--;
        end else if (pending_requests.size() != 0
                && !(pending_requests[0].drain_first && expected_responses.size() != 0)) begin
            req = pending_requests.pop_front();
            s_axis_tdata  <= {6'd0, req.item_value, req.position, req.cmd};
            s_axis_tvalid <= 1'b1;
            send_gap = pick_gap();
        end else begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // Response side backpressure; also open calm stretches now and then.
    always @(negedge i_clk) begin
        if (calm_cycles > 0) begin
            calm_cycles--;
        end else if ($urandom_range(0, 499) == 0) begin
            calm_cycles = $urandom_range(100, 300);
        end
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (recv_stall > 0) begin
            m_axis_tready <= 1'b0;
            recv_stall--;
        end else begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 7) == 0) recv_stall = pick_gap();
        end
    end

    // Monitor: check responses first, then predict for the request taken at
    // the same edge, so ordering within the edge never matters.
    always @(posedge i_clk) begin
        t_list_response got;
        t_list_response want;
        if (!i_rst_n) begin
            req_taken <= 1'b0;
        end else begin
            req_taken <= s_axis_tvalid && s_axis_tready;
            if (m_axis_tvalid && m_axis_tready) begin
                got.status    = m_axis_tdata[1:0];
                got.out_value = m_axis_tdata[33:2];
                got.count     = m_axis_tdata[40:34];
                if (expected_responses.size() == 0) begin
                    report_mismatch("unexpected response, status", 0, got.status);
                end else begin
                    want = expected_responses.pop_front();
                    if (got.status !== want.status)
                        report_mismatch("status", want.status, got.status);
                    if (got.out_value !== want.out_value)
                        report_mismatch("out_value", want.out_value, got.out_value);
                    if (got.count !== want.count)
                        report_mismatch("count", want.count, got.count);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_responses.push_back(apply_list_command(
                    s_axis_tdata[2:0], s_axis_tdata[9:3], s_axis_tdata[41:10]));
        end
    end

    initial begin
        #(CLK_PERIOD * 1_000_000);
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        t_phase_kind phase;
        int phase_len;
        int ins_pct;
        int rem_pct;
        int r;
        int k;
        int limit;
        bit drain_phase;
        bit first_phase;
        logic [CMD_W-1:0] cmd;

        // Directed: empty list corners, edge values, every command.
        queue_request(CMD_REM_FRONT, 0, '0, 1'b0);
        queue_request(CMD_REM_END, 0, '0, 1'b0);
        queue_request(CMD_REM_AT, 0, '0, 1'b0);
        queue_request(CMD_READ, 0, '0, 1'b0);
        queue_request(CMD_INS_AT, 1, 32'h1234_5678, 1'b0);   // beyond count
        queue_request(CMD_INS_AT, 0, 32'hFFFF_FFFF, 1'b0);
        queue_request(CMD_INS_FRONT, 0, 32'h0000_0000, 1'b0);
        queue_request(CMD_INS_END, 127, 32'h8000_0000, 1'b0);
        queue_request(CMD_INS_AT, 3, 32'h0000_0001, 1'b0);   // equal to count: append
        queue_request(CMD_INS_AT, 2, 32'hA5A5_5A5A, 1'b0);
        queue_request(CMD_READ, 0, 32'hFFFF_FFFF, 1'b0);
        queue_request(CMD_READ, 4, '0, 1'b0);
        queue_request(CMD_READ, 5, '0, 1'b0);                // equal to count
        queue_request(CMD_READ, 127, '0, 1'b0);
        queue_request(CMD_REM_AT, 64, '0, 1'b0);
        queue_request(CMD_REM_AT, 2, '0, 1'b0);
        queue_request(CMD_UNDEFINED, 127, 32'hFFFF_FFFF, 1'b0);
        queue_request(CMD_REM_END, 0, '0, 1'b0);
        queue_request(CMD_REM_FRONT, 0, '0, 1'b0);
        queue_request(CMD_REM_AT, 1, '0, 1'b0);
        queue_request(CMD_REM_AT, 0, '0, 1'b0);
        queue_request(CMD_READ, 0, '0, 1'b0);

        // Random: phases that grow, shrink or churn the list. The first one
        // grows long enough to hit a full list.
        first_phase = 1'b1;
        while (request_total < TARGET_REQS) begin
            phase       = first_phase ? PH_GROW : t_phase_kind'($urandom_range(0, 2));
            phase_len   = first_phase ? 200 : $urandom_range(40, 160);
            drain_phase = first_phase || ($urandom_range(0, 2) == 0);
            case (phase)
                PH_GROW:   begin ins_pct = 75; rem_pct = 15; end
                PH_SHRINK: begin ins_pct = 15; rem_pct = 75; end
                default:   begin ins_pct = 40; rem_pct = 40; end
            endcase
            for (k = 0; k < phase_len && request_total < TARGET_REQS; k++) begin
                r = $urandom_range(0, 99);
                if (r < 3) begin
                    cmd = CMD_UNDEFINED;
                    limit = 127;
                end else if (r < 3 + ins_pct) begin
                    case ($urandom_range(0, 2))
                        0:       cmd = CMD_INS_FRONT;
                        1:       cmd = CMD_INS_END;
                        default: cmd = CMD_INS_AT;
                    endcase
                    limit = planned_count;
                end else begin
                    if (r < 3 + ins_pct + rem_pct) begin
                        case ($urandom_range(0, 2))
                            0:       cmd = CMD_REM_FRONT;
                            1:       cmd = CMD_REM_END;
                            default: cmd = CMD_REM_AT;
                        endcase
                    end else begin
                        cmd = CMD_READ;
                    end
                    limit = (planned_count > 0) ? planned_count - 1 : 0;
                end
                queue_request(cmd, pick_position(limit), pick_value(), drain_phase && k == 0);
            end
            first_phase = 1'b0;
        end

        // Hold reset, then release it on a falling edge.
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_requests.size() != 0 || s_axis_tvalid
                || expected_responses.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (mismatch_count == 0 && expected_responses.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[positional_list_store.f]
sv/pls_pkg.sv
sv/pls_cell.sv
sv/pls_select_tree.sv
sv/positional_list_store.sv
sv/pls_checker.sv
bench/tb_positional_list_store.sv
